// ===== rtl/csm_pkg.sv =====
// Shared types, codes and step functions for the clock setting menu controller.
package csm_pkg;

    // Menu mode codes
    localparam logic [1:0] MODE_SHOW   = 2'd0;
    localparam logic [1:0] MODE_CHOOSE = 2'd1;
    localparam logic [1:0] MODE_ADJUST = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Selectable item codes
    localparam logic [2:0] ITEM_HOUR     = 3'd0;
    localparam logic [2:0] ITEM_MINUTE   = 3'd1;
    localparam logic [2:0] ITEM_AL_HOUR  = 3'd2;
    localparam logic [2:0] ITEM_AL_MIN   = 3'd3;
    localparam logic [2:0] ITEM_AL_EN    = 3'd4;

    // Value limits
    localparam logic [4:0] HOUR_LAST   = 5'd23;
    localparam logic [5:0] MINUTE_LAST = 6'd59;

    // Long press threshold after reset
    localparam logic [7:0] LONG_PRESS_RESET = 8'd40;

    // Button state after one tick, before any menu-driven clear
    typedef struct packed {
        logic plus;
        logic minus;
        logic plus_long;
        logic minus_long;
    } t_btn;

    // One result request
    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] item;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       alarm_on;
        logic       save;
    } t_result;

    // Step the selected item up, wrapping over five entries
    function automatic logic [2:0] item_inc(input logic [2:0] v);
        return (v == ITEM_AL_EN) ? ITEM_HOUR : v + 3'd1;
    endfunction

    // Step the selected item down, wrapping over five entries
    function automatic logic [2:0] item_dec(input logic [2:0] v);
        return (v == ITEM_HOUR) ? ITEM_AL_EN : v - 3'd1;
    endfunction

    // Step an hour value up or down, wrapping at 24
    function automatic logic [4:0] hour_step(input logic [4:0] v, input logic up);
        if (up) begin
            return (v >= HOUR_LAST) ? 5'd0 : v + 5'd1;
        end
        return (v == 5'd0 || v > HOUR_LAST) ? HOUR_LAST : v - 5'd1;
    endfunction

    // Step a minute value up or down, wrapping at 60
    function automatic logic [5:0] minute_step(input logic [5:0] v, input logic up);
        if (up) begin
            return (v >= MINUTE_LAST) ? 6'd0 : v + 6'd1;
        end
        return (v == 6'd0 || v > MINUTE_LAST) ? MINUTE_LAST : v - 6'd1;
    endfunction

endpackage

// ===== rtl/csm_buttons.sv =====
// Press timer, previous levels and long-press flags for the plus and minus buttons.
module csm_buttons (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_plus,
    input  logic              i_minus,
    input  logic [7:0]        i_threshold,
    input  logic              i_clear,
    output csm_pkg::t_btn     o_btn
);
    import csm_pkg::*;

    logic [7:0] r_timer;
    logic       r_plus_prev;
    logic       r_minus_prev;
    logic       r_plus_long;
    logic       r_minus_long;

    logic [7:0] inc_timer;
    logic [7:0] plus_timer;
    logic [7:0] n_timer;
    logic       n_plus_long;
    logic       n_minus_long;

    // Advance the timer and evaluate plus first, then minus
    always_comb begin
        inc_timer  = (r_timer == 8'hFF) ? r_timer : r_timer + 8'd1;
        plus_timer = (i_plus && !r_plus_prev) ? 8'd0 : inc_timer;

        n_plus_long = r_plus_long;
        if (!i_plus && r_plus_prev) begin
            n_plus_long = 1'b0;
        end
        if (i_plus && (plus_timer > i_threshold)) begin
            n_plus_long = 1'b1;
        end

        n_timer = (i_minus && !r_minus_prev) ? 8'd0 : plus_timer;

        n_minus_long = r_minus_long;
        if (!i_minus && r_minus_prev) begin
            n_minus_long = 1'b0;
        end
        if (i_minus && (n_timer > i_threshold)) begin
            n_minus_long = 1'b1;
        end
    end

    assign o_btn.plus       = i_plus;
    assign o_btn.minus      = i_minus;
    assign o_btn.plus_long  = n_plus_long;
    assign o_btn.minus_long = n_minus_long;

    // Hold button state; drop levels and flags on a mode change, keep the timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer      <= 8'd0;
            r_plus_prev  <= 1'b0;
            r_minus_prev <= 1'b0;
            r_plus_long  <= 1'b0;
            r_minus_long <= 1'b0;
        end else if (i_adv) begin
            r_timer      <= n_timer;
            r_plus_prev  <= i_clear ? 1'b0 : i_plus;
            r_minus_prev <= i_clear ? 1'b0 : i_minus;
            r_plus_long  <= i_clear ? 1'b0 : n_plus_long;
            r_minus_long <= i_clear ? 1'b0 : n_minus_long;
        end
    end

endmodule

// ===== rtl/csm_menu.sv =====
// Three-mode menu: item selection, value adjustment and save strobe.
module csm_menu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  csm_pkg::t_btn     i_btn,
    output logic              o_clear,
    output csm_pkg::t_result  o_res
);
    import csm_pkg::*;

    logic [1:0] r_mode;
    logic [2:0] r_item;
    logic [4:0] r_hour;
    logic [5:0] r_minute;
    logic [4:0] r_alarm_hour;
    logic [5:0] r_alarm_minute;
    logic       r_alarm_on;

    logic [1:0] n_mode;
    logic [2:0] n_item;
    logic [4:0] n_hour;
    logic [5:0] n_minute;
    logic [4:0] n_alarm_hour;
    logic [5:0] n_alarm_minute;
    logic       n_alarm_on;
    logic       n_save;
    logic       n_clear;

    // Work out the next menu state for one tick
    always_comb begin
        n_mode         = r_mode;
        n_item         = r_item;
        n_hour         = r_hour;
        n_minute       = r_minute;
        n_alarm_hour   = r_alarm_hour;
        n_alarm_minute = r_alarm_minute;
        n_alarm_on     = r_alarm_on;
        n_save         = 1'b0;
        n_clear        = 1'b0;

        unique case (r_mode)
            MODE_CHOOSE: begin
                if (i_btn.plus && !i_btn.minus) begin
                    n_item = item_inc(r_item);
                end else if (i_btn.minus && !i_btn.plus) begin
                    n_item = item_dec(r_item);
                end
                if (i_btn.plus_long && i_btn.minus_long) begin
                    n_mode  = MODE_SHOW;
                    n_clear = 1'b1;
                end else if (i_btn.plus_long || i_btn.minus_long) begin
                    n_mode  = MODE_ADJUST;
                    n_clear = 1'b1;
                end
            end
            MODE_ADJUST: begin
                if (i_btn.plus || i_btn.minus) begin
                    unique case (r_item)
                        ITEM_HOUR:    n_hour         = hour_step(r_hour, i_btn.plus);
                        ITEM_MINUTE:  n_minute       = minute_step(r_minute, i_btn.plus);
                        ITEM_AL_HOUR: n_alarm_hour   = hour_step(r_alarm_hour, i_btn.plus);
                        ITEM_AL_MIN:  n_alarm_minute = minute_step(r_alarm_minute,
                                                                   i_btn.plus);
                        default:      n_alarm_on     = ~r_alarm_on;
                    endcase
                end
                if (i_btn.plus_long || i_btn.minus_long) begin
                    n_save  = 1'b1;
                    n_mode  = MODE_CHOOSE;
                    n_clear = 1'b1;
                end
            end
            default: begin
                // show time, and the unused code acts the same
                n_mode = MODE_SHOW;
                if (i_btn.plus_long && i_btn.minus_long) begin
                    n_mode  = MODE_CHOOSE;
                    n_clear = 1'b1;
                end
            end
        endcase
    end

    assign o_clear            = n_clear;
    assign o_res.mode         = n_mode;
    assign o_res.item         = n_item;
    assign o_res.hour         = n_hour;
    assign o_res.minute       = n_minute;
    assign o_res.alarm_hour   = n_alarm_hour;
    assign o_res.alarm_minute = n_alarm_minute;
    assign o_res.alarm_on     = n_alarm_on;
    assign o_res.save         = n_save;

    // Advance the menu state once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_SHOW;
            r_item         <= ITEM_HOUR;
            r_hour         <= 5'd0;
            r_minute       <= 6'd0;
            r_alarm_hour   <= 5'd0;
            r_alarm_minute <= 6'd0;
            r_alarm_on     <= 1'b0;
        end else if (i_adv) begin
            r_mode         <= n_mode;
            r_item         <= n_item;
            r_hour         <= n_hour;
            r_minute       <= n_minute;
            r_alarm_hour   <= n_alarm_hour;
            r_alarm_minute <= n_alarm_minute;
            r_alarm_on     <= n_alarm_on;
        end
    end

endmodule

// ===== rtl/clock_setting_menu_controller.sv =====
// A tick request is captured in the input register, passes through the button and menu
// logic and is held as a result request in the output register until it is taken.
// Throughput: one tick per cycle while the output side does not stall.
// While the output side stalls, the input register takes one more request, then stalls.
// Reset (synchronous, active low): menu shows time, all values, flags and timer zero,
// long press threshold 40.
module clock_setting_menu_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_plus_pressed,
    input  logic       i_minus_pressed,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_menu_mode,
    output logic [2:0] o_selected_item,
    output logic [4:0] o_hour_value,
    output logic [5:0] o_minute_value,
    output logic [4:0] o_alarm_hour_value,
    output logic [5:0] o_alarm_minute_value,
    output logic       o_alarm_on,
    output logic       o_save_strobe,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);
    import csm_pkg::*;

    logic [7:0] r_threshold;
    logic       r_in_valid;
    logic       r_in_plus;
    logic       r_in_minus;
    logic       r_out_valid;
    t_result    r_res;

    logic       out_free;
    logic       adv;
    logic       in_load;
    logic       clear;
    t_btn       btn;
    t_result    res;

    // Handshake between the input register and the output register
    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_load  = i_valid && !o_stall;

    // Hold the long press threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // Capture the incoming tick request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_plus  <= i_plus_pressed;
            r_in_minus <= i_minus_pressed;
        end
    end

    csm_buttons u_buttons (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_plus      (r_in_plus),
        .i_minus     (r_in_minus),
        .i_threshold (r_threshold),
        .i_clear     (clear),
        .o_btn       (btn)
    );

    csm_menu u_menu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_btn   (btn),
        .o_clear (clear),
        .o_res   (res)
    );

    // Hold the result request until the output side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_menu_mode          = r_res.mode;
    assign o_selected_item      = r_res.item;
    assign o_hour_value         = r_res.hour;
    assign o_minute_value       = r_res.minute;
    assign o_alarm_hour_value   = r_res.alarm_hour;
    assign o_alarm_minute_value = r_res.alarm_minute;
    assign o_alarm_on           = r_res.alarm_on;
    assign o_save_strobe        = r_res.save;

`ifndef NO_ASSERTIONS
    // A save only happens on the way back to choosing a parameter
    a_save_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_save_strobe) |-> (o_menu_mode == MODE_CHOOSE))
        else $error("save strobe outside the return to choose mode");

    // Mode code three never leaves the block
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_menu_mode != MODE_UNUSED))
        else $error("unused menu mode code on output");

    // Item and values stay in range
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_selected_item <= ITEM_AL_EN) && (o_hour_value <= HOUR_LAST)
            && (o_minute_value <= MINUTE_LAST) && (o_alarm_hour_value <= HOUR_LAST)
            && (o_alarm_minute_value <= MINUTE_LAST)))
        else $error("result field out of range");

    // A pending input request is moved on whenever the output register frees up
    a_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free && !in_load) |=> !r_in_valid)
        else $error("input request not moved to output register");
`endif

endmodule

// ===== verif/clock_setting_menu_controller_test.sv =====
// Self-checking testbench for the clock setting menu controller.
`timescale 1ns / 100ps

module clock_setting_menu_controller_test;
    import csm_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int BUSY_PCT        = 20;

    // One directed row: optional threshold write, button levels, optional fixed result
    typedef struct packed {
        logic       wr;
        logic [7:0] thr;
        logic       p;
        logic       m;
        logic       typed;
        t_result    res;
    } t_dir_row;

    localparam t_result RES_ZERO   = '0;
    localparam t_result RES_CHOOSE = t_result'({MODE_CHOOSE, 27'd0});

    localparam int DIR_ROWS = 24;
    // Enter choose, adjust alarm minute with a wrap, toggle alarm enable,
    // then wrap the minute both ways at a threshold of one.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{1'b0, 8'd0, 1'b0, 1'b0, 1'b1, RES_ZERO},
        '{1'b1, 8'd0, 1'b1, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b1, 1'b1, 1'b1, RES_CHOOSE},
        '{1'b0, 8'd0, 1'b0, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b1, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b1, 1'b1, 1'b0, RES_ZERO},
        '{1'b1, 8'd1, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b1, 1'b0, 1'b0, RES_ZERO},
        '{1'b0, 8'd0, 1'b0, 1'b0, 1'b0, RES_ZERO}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_plus_pressed;
    logic       i_minus_pressed;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_menu_mode;
    logic [2:0] o_selected_item;
    logic [4:0] o_hour_value;
    logic [5:0] o_minute_value;
    logic [4:0] o_alarm_hour_value;
    logic [5:0] o_alarm_minute_value;
    logic       o_alarm_on;
    logic       o_save_strobe;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    // Predicted menu state
    logic [7:0] pr_thr;
    logic [1:0] pr_mode;
    logic [2:0] pr_item;
    logic [4:0] pr_hour;
    logic [5:0] pr_minute;
    logic [4:0] pr_al_hour;
    logic [5:0] pr_al_minute;
    logic       pr_al_on;
    logic       pr_plus_prev;
    logic       pr_minus_prev;
    logic       pr_plus_long;
    logic       pr_minus_long;
    logic [7:0] pr_press_timer;

    t_result menu_results_due[$];

    int error_cnt;
    int tick_cnt;
    int checked_cnt;
    int save_cnt;
    int cfg_cnt;
    int cycle_cnt;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_off_asks;
    int hold_off_seen;
    int hold_off_left;

    clock_setting_menu_controller dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_plus_pressed       (i_plus_pressed),
        .i_minus_pressed      (i_minus_pressed),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_menu_mode          (o_menu_mode),
        .o_selected_item      (o_selected_item),
        .o_hour_value         (o_hour_value),
        .o_minute_value       (o_minute_value),
        .o_alarm_hour_value   (o_alarm_hour_value),
        .o_alarm_minute_value (o_alarm_minute_value),
        .o_alarm_on           (o_alarm_on),
        .o_save_strobe        (o_save_strobe),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata)
    );

    // Generate the clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Step a value up or down, wrapping between zero and last
    function automatic logic [5:0] wrap_value(input logic [5:0] v, input logic up,
                                              input logic [5:0] last);
        if (up) begin
            return (v >= last) ? 6'd0 : v + 6'd1;
        end
        return (v == 6'd0 || v > last) ? last : v - 6'd1;
    endfunction

    // Drop both button histories and long-press flags on a mode change
    function automatic void drop_buttons();
        pr_plus_prev  = 1'b0;
        pr_minus_prev = 1'b0;
        pr_plus_long  = 1'b0;
        pr_minus_long = 1'b0;
    endfunction

    // Advance the predicted menu by one tick and return its result request
    function automatic t_result calc_menu_tick(input logic p, input logic m);
        t_result r;
        int      idx;
        logic    up;
        logic    save;

        save = 1'b0;
        if (pr_press_timer != 8'hFF) pr_press_timer = pr_press_timer + 8'd1;

        if (p && !pr_plus_prev) pr_press_timer = 8'd0;
        if (!p && pr_plus_prev) pr_plus_long = 1'b0;
        if (p && pr_press_timer > pr_thr) pr_plus_long = 1'b1;

        if (m && !pr_minus_prev) pr_press_timer = 8'd0;
        if (!m && pr_minus_prev) pr_minus_long = 1'b0;
        if (m && pr_press_timer > pr_thr) pr_minus_long = 1'b1;

        pr_plus_prev  = p;
        pr_minus_prev = m;

        case (pr_mode)
            MODE_CHOOSE: begin
                idx = int'(pr_item);
                if (p) idx = (idx + 1) % 5;
                if (m) idx = (idx + 4) % 5;
                pr_item = 3'(idx);
                if (pr_plus_long && pr_minus_long) begin
                    pr_mode = MODE_SHOW;
                    drop_buttons();
                end else if (pr_plus_long || pr_minus_long) begin
                    pr_mode = MODE_ADJUST;
                    drop_buttons();
                end
            end
            MODE_ADJUST: begin
                if (p || m) begin
                    up = p;
                    case (pr_item)
                        ITEM_HOUR:
                            pr_hour = 5'(wrap_value({1'b0, pr_hour}, up, {1'b0, HOUR_LAST}));
                        ITEM_MINUTE:
                            pr_minute = wrap_value(pr_minute, up, MINUTE_LAST);
                        ITEM_AL_HOUR:
                            pr_al_hour = 5'(wrap_value({1'b0, pr_al_hour}, up,
                                                       {1'b0, HOUR_LAST}));
                        ITEM_AL_MIN:
                            pr_al_minute = wrap_value(pr_al_minute, up, MINUTE_LAST);
                        default:
                            pr_al_on = ~pr_al_on;
                    endcase
                end
                if (pr_plus_long || pr_minus_long) begin
                    save    = 1'b1;
                    pr_mode = MODE_CHOOSE;
                    drop_buttons();
                end
            end
            default: begin
                pr_mode = MODE_SHOW;
                if (pr_plus_long && pr_minus_long) begin
                    pr_mode = MODE_CHOOSE;
                    drop_buttons();
                end
            end
        endcase

        r.mode         = pr_mode;
        r.item         = pr_item;
        r.hour         = pr_hour;
        r.minute       = pr_minute;
        r.alarm_hour   = pr_al_hour;
        r.alarm_minute = pr_al_minute;
        r.alarm_on     = pr_al_on;
        r.save         = save;
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("mode=%0d item=%0d %0d:%0d alarm %0d:%0d on=%0b save=%0b",
                         r.mode, r.item, r.hour, r.minute, r.alarm_hour,
                         r.alarm_minute, r.alarm_on, r.save);
    endfunction

    task automatic note_error(input string msg);
        error_cnt++;
        if (error_cnt <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    // Offer one tick request after a random gap; record its result once accepted
    task automatic send_tick(input logic p, input logic m, input logic typed,
                             input t_result fixed);
        t_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_plus_pressed  = p;
        i_minus_pressed = m;
        do @(posedge i_clk); while (o_stall);
        predicted = calc_menu_tick(p, m);
        menu_results_due.push_back(typed ? fixed : predicted);
        tick_cnt++;
        @(negedge i_clk);
    endtask

    // Write the long-press threshold once the block has drained
    task automatic set_long_press(input logic [7:0] v);
        i_valid = 1'b0;
        while (menu_results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        pr_thr   = v;
        cfg_cnt++;
    endtask

    // Run random button gestures at one threshold: mostly holds, some noise
    task automatic run_phase(input logic [7:0] thr, input int n_items, input bit quiet);
        int   stop;
        int   kind;
        int   span;
        int   len;
        logic bp;

        set_long_press(thr);
        if (quiet) begin
            src_idle_pct  = 0;
            snk_stall_pct = 0;
            hold_off_asks++;
        end
        stop = tick_cnt + n_items;
        while (tick_cnt < stop) begin
            kind = $urandom_range(99);
            span = (int'(pr_thr) + 3 > 270) ? 270 : int'(pr_thr) + 3;
            if (kind < 30) begin
                // hold both near the threshold, at times long enough to flip the menu, then release
                len = $urandom_range((span > 3) ? span - 3 : 1, span);
                repeat (len) send_tick(1'b1, 1'b1, 1'b0, RES_ZERO);
                repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0, 1'b0, RES_ZERO);
            end else if (kind < 75) begin
                bp  = 1'($urandom_range(1));
                len = $urandom_range(1, span);
                repeat (len) send_tick(bp, ~bp, 1'b0, RES_ZERO);
                repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'b0, 1'b0, RES_ZERO);
            end else if (kind < 85) begin
                len = $urandom_range(1, span);
                repeat (len) send_tick(1'b1, 1'b1, 1'b0, RES_ZERO);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, RES_ZERO);
                end
            end
        end
        src_idle_pct  = BUSY_PCT;
        snk_stall_pct = BUSY_PCT;
    endtask

    // Drive the receiver stall: random, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall       = 1'b1;
            hold_off_left = hold_off_left - 1;
        end else if (hold_off_asks != hold_off_seen) begin
            hold_off_seen = hold_off_asks;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            i_stall       = 1'b1;
        end else begin
            i_stall = ($urandom_range(99) < snk_stall_pct);
        end
    end

    // Check each accepted result request against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_menu_mode, o_selected_item, o_hour_value, o_minute_value,
                   o_alarm_hour_value, o_alarm_minute_value, o_alarm_on, o_save_strobe};
            checked_cnt++;
            if (got.save) save_cnt++;
            if (menu_results_due.size() == 0) begin
                note_error($sformatf("result with nothing pending: %s", fmt_result(got)));
            end else begin
                want = menu_results_due.pop_front();
                if (got !== want) begin
                    note_error($sformatf("tick result mismatch: expected %s, got %s",
                                         fmt_result(want), fmt_result(got)));
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, menu_results_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_plus_pressed  = 1'b0;
        i_minus_pressed = 1'b0;
        i_stall         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 8'd0;
        error_cnt       = 0;
        tick_cnt        = 0;
        checked_cnt     = 0;
        save_cnt        = 0;
        cfg_cnt         = 0;
        cycle_cnt       = 0;
        src_idle_pct    = BUSY_PCT;
        snk_stall_pct   = BUSY_PCT;
        hold_off_asks   = 0;
        hold_off_seen   = 0;
        hold_off_left   = 0;

        pr_thr         = LONG_PRESS_RESET;
        pr_mode        = MODE_SHOW;
        pr_item        = ITEM_HOUR;
        pr_hour        = '0;
        pr_minute      = '0;
        pr_al_hour     = '0;
        pr_al_minute   = '0;
        pr_al_on       = 1'b0;
        pr_press_timer = '0;
        drop_buttons();

        // Hold reset, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].wr) set_long_press(DIR_TABLE[i].thr);
            send_tick(DIR_TABLE[i].p, DIR_TABLE[i].m, DIR_TABLE[i].typed, DIR_TABLE[i].res);
        end

        // Random gestures over several thresholds, extremes included
        run_phase(8'd1, 200, 1'b0);
        run_phase(8'd255, 120, 1'b0);
        run_phase(8'd2, 200, 1'b1);
        run_phase(8'd0, 150, 1'b0);
        run_phase(LONG_PRESS_RESET, 220, 1'b0);
        run_phase(8'($urandom_range(1, 6)), 200, 1'b0);

        // Drain and let the pipeline settle
        i_valid = 1'b0;
        while (menu_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d ticks under %0d threshold writes; %0d results checked, %0d saves.",
                 tick_cnt, cfg_cnt, checked_cnt, save_cnt);
        $display("Mismatch count: %0d over %0d cycles.", error_cnt, cycle_cnt);
        if (error_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/csm_pkg.sv
rtl/csm_buttons.sv
rtl/csm_menu.sv
rtl/clock_setting_menu_controller.sv
verif/clock_setting_menu_controller_test.sv
